// File: sv/heater_load_check_and_duty_select_unit_macros.svh
// ----------------------------------------------------------------------------
// Heater load check assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef HEATER_LOAD_CHECK_AND_DUTY_SELECT_UNIT_MACROS_SVH
`define HEATER_LOAD_CHECK_AND_DUTY_SELECT_UNIT_MACROS_SVH

// same-cycle implication
`define HLCDS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hlcds assertion failed");

// next-cycle implication
`define HLCDS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hlcds assertion failed");

`endif

// File: sv/hlcds_pkg.sv
// ----------------------------------------------------------------------------
// Heater load check package
// Widths, codes and status types shared by the divider and the top level.
// ----------------------------------------------------------------------------
package hlcds_pkg;

   // ADC reading width
   localparam int ADC_BITS = 12;
   // numerator (ten times a reading) width
   localparam int NUM_BITS = ADC_BITS + 4;
   // divider iteration counter width
   localparam int DIV_CNT_W = $clog2(NUM_BITS + 1);
   // resistance figure width and saturation value
   localparam int RES_BITS = 16;
   localparam logic [RES_BITS-1:0] RES_MAX = {RES_BITS{1'b1}};

   // stream packing
   localparam int REQ_DATA_BITS = 3 * ADC_BITS;
   localparam int REQ_DATA_W    = ((REQ_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = 8 + RES_BITS + ADC_BITS;
   localparam int RSP_DATA_W    = ((RSP_DATA_BITS + 7) / 8) * 8;

   // outcome codes
   localparam logic [1:0] STATUS_FIRING = 2'd0;
   localparam logic [1:0] STATUS_SHORT  = 2'd1;
   localparam logic [1:0] STATUS_OPEN   = 2'd2;

   // duty values
   localparam logic [7:0] DUTY_OFF  = 8'd156;
   localparam logic [7:0] DUTY_FULL = 8'd1;

   // register indexes
   localparam logic [1:0] REG_VALID_VOLT_MIN   = 2'd0;
   localparam logic [1:0] REG_SHORT_RES_LIMIT  = 2'd1;
   localparam logic [1:0] REG_SHORT_VOLT_LIMIT = 2'd2;
   localparam logic [1:0] REG_OPEN_DIFF_LIMIT  = 2'd3;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: sv/hlcds_div.sv
// ----------------------------------------------------------------------------
// Heater load check bit-serial divider
// Restoring divider: one quotient bit per cycle, numerator shifted out MSB
// first while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module hlcds_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hlcds_pkg::NUM_BITS-1:0] num,
   input  logic [hlcds_pkg::ADC_BITS-1:0] den,
   output logic [hlcds_pkg::NUM_BITS-1:0] quotient,
   output hlcds_pkg::div_stat_type       stat
);

   logic [hlcds_pkg::NUM_BITS-1:0]  quo_ff, quo_in;
   logic [hlcds_pkg::ADC_BITS-1:0]  rem_ff, rem_in;
   logic [hlcds_pkg::ADC_BITS-1:0]  den_ff, den_in;
   logic [hlcds_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [hlcds_pkg::ADC_BITS:0]    trial;
   logic [hlcds_pkg::ADC_BITS:0]    trial_sub;
   logic                            fits;

   // trial subtract of one step
   always_comb begin
      trial     = {rem_ff, quo_ff[hlcds_pkg::NUM_BITS-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = (trial >= {1'b0, den_ff});
   end

   // load on start, then shift one digit per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = hlcds_pkg::DIV_CNT_W'(hlcds_pkg::NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[hlcds_pkg::NUM_BITS-2:0], fits};
         rem_in = fits ? trial_sub[hlcds_pkg::ADC_BITS-1:0]
                       : trial[hlcds_pkg::ADC_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == hlcds_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// File: sv/heater_load_check_and_duty_select_unit.sv
// ----------------------------------------------------------------------------
// Heater load check and duty select unit
// Checks the heater load once per firing period, holds the load difference
// and resistance figure, and reports short, open or firing with a PWM duty.
// ----------------------------------------------------------------------------
//  channel | role      | beat contents
//  req_    | input     | tdata: battery, high side, low side readings
//  rsp_    | output    | tdata: duty, resistance, difference; tuser: status
//  csr_    | config    | APB write/read of the four limit registers
//
//  An item steps through CALC and FIN, with DIV between them when a division
//  is needed; the bit-serial divider, one quotient bit a cycle, paces DIV.
//  One item is in work at a time; req_tready is high only when idle.
//  A finished beat waits in the output register while the next is taken;
//  a stalled rsp_ holds the sequencer before its load.
//  Reset is synchronous: limits return to defaults, held pair to zero.
// ----------------------------------------------------------------------------
`include "heater_load_check_and_duty_select_unit_macros.svh"

module heater_load_check_and_duty_select_unit (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: battery_level, load_high_side, load_low_side, zero pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hlcds_pkg::REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata: duty, resistance, volt_difference, zero pad
   // rsp_tuser: status
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hlcds_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]                        rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [3:0]                        csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   localparam int AB = hlcds_pkg::ADC_BITS;
   localparam int RB = hlcds_pkg::RES_BITS;
   localparam int NB = hlcds_pkg::NUM_BITS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [AB-1:0] vmin_ff, svolt_ff, odiff_ff;
   logic [RB-1:0] sres_ff;
   logic [AB-1:0] bat_ff, lo_ff, diff_ff;
   logic          upd_ff;
   logic [AB-1:0] held_diff_ff, held_diff_in;
   logic [RB-1:0] held_res_ff, held_res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    duty_ff, duty_in;
   logic [1:0]    status_ff, status_in;
   logic [RB-1:0] out_res_ff;
   logic [AB-1:0] out_diff_ff;

   logic          in_beat, out_load, cfg_wr;
   logic [AB-1:0] bat_w, hi_w, lo_w, diff_w;
   logic [NB-1:0] num_w, quo_w;
   logic [NB+RB-1:0] quo_wide;
   logic [RB-1:0] quo_sat;
   logic          div_start;
   hlcds_pkg::div_stat_type div_stat;

   // duty from battery bands
   function automatic logic [7:0] band_duty(input logic [AB-1:0] bat);
      logic [31:0] b;
      logic [7:0]  d;
      b = 32'(bat);
      if (b <= 32'h9DD)      d = hlcds_pkg::DUTY_FULL;
      else if (b <= 32'hA22) d = 8'd5;
      else if (b <= 32'hA66) d = 8'd13;
      else if (b <= 32'hAAB) d = 8'd19;
      else if (b <= 32'hAEF) d = 8'd27;
      else                   d = 8'd33;
      return d;
   endfunction

   assign in_beat  = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign cfg_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // unpack the input beat
   assign bat_w  = req_tdata[AB-1:0];
   assign hi_w   = req_tdata[2*AB-1:AB];
   assign lo_w   = req_tdata[3*AB-1:2*AB];
   assign diff_w = (lo_w > hi_w) ? (lo_w - hi_w) : (hi_w - lo_w);

   // ten times the low side as shift and add
   assign num_w = (NB'(lo_ff) << 3) + (NB'(lo_ff) << 1);

   assign div_start = (state_ff == ST_CALC) && upd_ff && (diff_ff != '0);

   hlcds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_w),
      .den      (diff_ff),
      .quotient (quo_w),
      .stat     (div_stat)
   );

   // saturate the quotient to the resistance width
   assign quo_wide = (NB+RB)'(quo_w);
   assign quo_sat  = (quo_wide > (NB+RB)'(hlcds_pkg::RES_MAX)) ? hlcds_pkg::RES_MAX
                                                               : quo_wide[RB-1:0];

   assign out_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);

   // sequence one item and update the held pair
   always_comb begin
      state_in     = state_ff;
      held_diff_in = held_diff_ff;
      held_res_in  = held_res_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_beat) state_in = ST_CALC;
         end
         ST_CALC: begin
            if (div_start) begin
               state_in = ST_DIV;
            end else begin
               if (upd_ff) begin
                  held_diff_in = diff_ff;
                  held_res_in  = hlcds_pkg::RES_MAX;
               end
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               held_diff_in = diff_ff;
               held_res_in  = quo_sat;
               state_in     = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // pick the outcome from the held pair, the low side and the battery reading
   always_comb begin
      if (held_res_ff < sres_ff || lo_ff < svolt_ff) begin
         duty_in   = hlcds_pkg::DUTY_OFF;
         status_in = hlcds_pkg::STATUS_SHORT;
      end else if (held_diff_ff < odiff_ff) begin
         duty_in   = hlcds_pkg::DUTY_OFF;
         status_in = hlcds_pkg::STATUS_OPEN;
      end else begin
         duty_in   = band_duty(bat_ff);
         status_in = hlcds_pkg::STATUS_FIRING;
      end
   end

   // hold the output beat until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load)        rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         held_diff_ff <= '0;
         held_res_ff  <= '0;
         vmin_ff      <= AB'(1365);
         sres_ff      <= RB'(100);
         svolt_ff     <= AB'(68);
         odiff_ff     <= AB'(25);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         held_diff_ff <= held_diff_in;
         held_res_ff  <= held_res_in;
         if (cfg_wr) begin
            case (csr_paddr[3:2])
               hlcds_pkg::REG_VALID_VOLT_MIN:   vmin_ff  <= csr_pwdata[AB-1:0];
               hlcds_pkg::REG_SHORT_RES_LIMIT:  sres_ff  <= csr_pwdata[RB-1:0];
               hlcds_pkg::REG_SHORT_VOLT_LIMIT: svolt_ff <= csr_pwdata[AB-1:0];
               hlcds_pkg::REG_OPEN_DIFF_LIMIT:  odiff_ff <= csr_pwdata[AB-1:0];
               default: ;
            endcase
         end
      end
   end

   // capture the input beat and the output payload
   always_ff @(posedge clock) begin
      if (in_beat) begin
         bat_ff  <= bat_w;
         lo_ff   <= lo_w;
         diff_ff <= diff_w;
         upd_ff  <= (lo_w > vmin_ff) && (hi_w > vmin_ff);
      end
      if (out_load) begin
         duty_ff     <= duty_in;
         status_ff   <= status_in;
         out_res_ff  <= held_res_ff;
         out_diff_ff <= held_diff_ff;
      end
   end

   // register read back
   always_comb begin
      case (csr_paddr[3:2])
         hlcds_pkg::REG_VALID_VOLT_MIN:   csr_prdata = 32'(vmin_ff);
         hlcds_pkg::REG_SHORT_RES_LIMIT:  csr_prdata = 32'(sres_ff);
         hlcds_pkg::REG_SHORT_VOLT_LIMIT: csr_prdata = 32'(svolt_ff);
         hlcds_pkg::REG_OPEN_DIFF_LIMIT:  csr_prdata = 32'(odiff_ff);
         default:                         csr_prdata = '0;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = hlcds_pkg::RSP_DATA_W'({out_diff_ff, out_res_ff, duty_ff});

   // a divider result arrives only while the sequencer waits for it
   `HLCDS_ASSERT_IMP(a_done_in_div, div_stat.done, state_ff == ST_DIV)
   // a stalled output keeps the sequencer from loading a new beat
   `HLCDS_ASSERT_NXT(a_stall_holds_fin,
                     (state_ff == ST_FIN) && rsp_valid_ff && !rsp_tready,
                     state_ff == ST_FIN)
   // a fault beat always carries the drive-off duty
   `HLCDS_ASSERT_IMP(a_fault_drive_off,
                     rsp_valid_ff && (status_ff != hlcds_pkg::STATUS_FIRING),
                     duty_ff == hlcds_pkg::DUTY_OFF)
   // the divider is idle whenever the sequencer is idle
   `HLCDS_ASSERT_IMP(a_div_idle, state_ff == ST_IDLE, !div_stat.busy)

endmodule
